@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define LFU_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lfu check failed");

// Checks that a signal holds while a transfer is stalled.
`define LFU_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> $stable(sig)) else $error("lfu hold check failed");

`endif

@@ rtl/lfu_pkg.sv @@
// Package with the types and constants of the LFU cache.
package lfu_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned CAP_BITS   = 5;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   operation;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] write_value;
  } lfu_in_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  stored;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } lfu_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } lfu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic cap_zero;
    logic out_free;
  } lfu_status_t;

endpackage

@@ rtl/lfu_ctrl.sv @@
// Controller state machine that sequences scan, decision and update.
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lfu_status_t status_i,
  output lfu_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_LAST  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = status_i.cap_zero ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        // The last entry read is evaluated in this cycle.
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/lfu_dp.sv @@
// Datapath with the entry store, the scan evaluation and the result register.
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CAP_BITS-1:0] cfg_data_i,
  input  lfu_in_t             in_data_i,
  input  lfu_cmd_t            cmd_i,
  output lfu_status_t         status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lfu_out_t            out_data_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned UW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = (UW > CAP_BITS) ? UW : CAP_BITS;

  // Entry store: valid bits in flops, the rest in memories.
  logic [ENTRIES-1:0]    valid_q;
  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [VALUE_BITS-1:0] value_mem [ENTRIES];
  logic [COUNT_BITS-1:0] count_mem [ENTRIES];
  logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];

  logic [CAP_BITS-1:0]   cap_q;
  logic [STAMP_BITS-1:0] stamp_q;
  lfu_in_t               req_q;

  // Scan read port.
  logic [IW-1:0]         scan_idx_q;
  logic                  rd_live_q;
  logic [IW-1:0]         rd_idx_q;
  logic                  rd_valid_q;
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_value_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  logic [STAMP_BITS-1:0] rd_stamp_q;

  // Scan results.
  logic                  found_q;
  logic [IW-1:0]         match_idx_q;
  logic [VALUE_BITS-1:0] match_val_q;
  logic [COUNT_BITS-1:0] match_cnt_q;
  logic [UW-1:0]         used_q;
  logic                  free_found_q;
  logic [IW-1:0]         free_idx_q;
  logic                  vic_found_q;
  logic [IW-1:0]         vic_idx_q;
  logic [KEY_BITS-1:0]   vic_key_q;
  logic [COUNT_BITS-1:0] vic_cnt_q;
  logic [STAMP_BITS-1:0] vic_age_q;

  logic                  out_valid_q;
  lfu_out_t              out_data_q, out_data_d;

  logic                  hit_now, vic_better, free_now;
  logic [STAMP_BITS-1:0] rd_age;
  logic [CW-1:0]         cap_ext, ent_ext, cap_eff;
  logic                  full, set_ok;
  logic [IW-1:0]         set_slot, wr_addr;
  logic                  wr_key_en, wr_cnt_en;
  logic [COUNT_BITS-1:0] wr_cnt;

  // Status toward the controller.
  assign status_o.scan_last = (scan_idx_q == IW'(ENTRIES - 1));
  assign status_o.cap_zero  = (cap_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Evaluation of the entry read in the previous cycle.
  assign rd_age     = stamp_q - rd_stamp_q;
  assign hit_now    = rd_live_q && rd_valid_q && !found_q && (rd_key_q == req_q.lookup_key);
  assign free_now   = rd_live_q && !rd_valid_q && !free_found_q;
  assign vic_better = rd_live_q && rd_valid_q &&
                      (!vic_found_q || (rd_cnt_q < vic_cnt_q) ||
                       ((rd_cnt_q == vic_cnt_q) && (rd_age > vic_age_q)));

  // Decision and update after the scan.
  always_comb begin
    cap_ext    = CW'(cap_q);
    ent_ext    = CW'(ENTRIES);
    cap_eff    = (cap_ext > ent_ext) ? ent_ext : cap_ext;
    full       = (CW'(used_q) >= cap_eff);
    set_slot   = found_q ? match_idx_q : (full ? vic_idx_q : free_idx_q);
    set_ok     = found_q || (full ? vic_found_q : free_found_q);
    wr_key_en  = 1'b0;
    wr_cnt_en  = 1'b0;
    wr_addr    = set_slot;
    wr_cnt     = COUNT_BITS'(1);
    out_data_d = '0;
    if (cmd_i.commit && !status_o.cap_zero) begin
      if (req_q.operation == OP_GET) begin
        if (found_q) begin
          out_data_d.hit        = 1'b1;
          out_data_d.read_value = match_val_q;
          wr_cnt_en             = 1'b1;
          wr_addr               = match_idx_q;
          // The use count saturates at its maximum.
          wr_cnt = (&match_cnt_q) ? match_cnt_q : (match_cnt_q + COUNT_BITS'(1));
        end
      end else if (set_ok) begin
        wr_key_en         = 1'b1;
        wr_cnt_en         = 1'b1;
        out_data_d.stored = 1'b1;
        if (!found_q && full) begin
          out_data_d.evicted     = 1'b1;
          out_data_d.evicted_key = vic_key_q;
        end
      end
    end
  end

  // Memories: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_mem[wr_addr]   <= req_q.lookup_key;
      value_mem[wr_addr] <= req_q.write_value;
    end
    if (wr_cnt_en) begin
      count_mem[wr_addr] <= wr_cnt;
      stamp_mem[wr_addr] <= stamp_q;
    end
    rd_key_q   <= key_mem[scan_idx_q];
    rd_value_q <= value_mem[scan_idx_q];
    rd_cnt_q   <= count_mem[scan_idx_q];
    rd_stamp_q <= stamp_mem[scan_idx_q];
    rd_valid_q <= valid_q[scan_idx_q];
    rd_idx_q   <= scan_idx_q;
  end

  // Payload registers of the request, the scan results and the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= in_data_i;
    end
    if (hit_now) begin
      match_idx_q <= rd_idx_q;
      match_val_q <= rd_value_q;
      match_cnt_q <= rd_cnt_q;
    end
    if (free_now) begin
      free_idx_q <= rd_idx_q;
    end
    if (vic_better) begin
      vic_idx_q <= rd_idx_q;
      vic_key_q <= rd_key_q;
      vic_cnt_q <= rd_cnt_q;
      vic_age_q <= rd_age;
    end
    if (cmd_i.commit) begin
      out_data_q <= out_data_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_BITS'(16);
      valid_q      <= '0;
      stamp_q      <= '0;
      scan_idx_q   <= '0;
      rd_live_q    <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      rd_live_q <= cmd_i.scan;
      if (cmd_i.start) begin
        scan_idx_q   <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
        vic_found_q  <= 1'b0;
        used_q       <= '0;
      end else begin
        if (cmd_i.scan) begin
          scan_idx_q <= scan_idx_q + IW'(1);
        end
        if (hit_now) begin
          found_q <= 1'b1;
        end
        if (free_now) begin
          free_found_q <= 1'b1;
        end
        if (vic_better) begin
          vic_found_q <= 1'b1;
        end
        if (rd_live_q && rd_valid_q) begin
          used_q <= used_q + UW'(1);
        end
      end
      if (wr_key_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (wr_cnt_en) begin
        stamp_q <= stamp_q + STAMP_BITS'(1);
      end
      // The result register is freed by an output transfer.
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/lfu_cache_replacement.sv @@
// Top level of the LFU cache with least-recently-stamped tie-break.
//
// Requests enter on the in channel (valid/ready): a get looks up a key, a set
// stores a key and a value handle. Each request gives exactly one result on
// the out channel (valid/ready) with hit, read value, stored, evicted and the
// evicted key. The cfg channel, always ready, writes the capacity register;
// the user must write it only while idle, as the block does not enforce it.
// After its transfer, each request runs a sequential scan with one read of
// the entry memories per entry, then a step in which the last read is
// evaluated, then the update and the result load; only then is the next
// request taken. A capacity of zero skips the scan and goes to the update.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, that next request waits before its update
// until the held result has been transferred.
// Reset empties the table, clears the stamp counter and sets capacity to 16.
module lfu_cache_replacement
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CAP_BITS-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lfu_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lfu_out_t            out_data_o
);

  lfu_cmd_t    cmd;
  lfu_status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  lfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Entry store and evaluation.
  lfu_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/lfu_checker.sv @@
// Port-level checker for the LFU cache and its bind statement.
`include "assert_macros.svh"

module lfu_checker
  import lfu_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input lfu_out_t out_data_i
);

  // A held result keeps its payload until transferred.
  `LFU_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_data_i)
  // One request at a time: after a request transfer, no request is taken at once.
  `LFU_ASSERT(a_one_busy, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i)
  // A result is never both a hit and a store.
  `LFU_ASSERT(a_hit_store, clk_i, rst_ni, out_valid_i |-> !(out_data_i.hit && out_data_i.stored))
  // An eviction only comes with a store.
  `LFU_ASSERT(a_evict_store, clk_i, rst_ni, (out_valid_i && out_data_i.evicted) |-> out_data_i.stored)
  // A miss returns a zero value.
  `LFU_ASSERT(a_miss_zero, clk_i, rst_ni,
    (out_valid_i && !out_data_i.hit) |-> (out_data_i.read_value == '0))

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
